// File: rtl/vspg_pkg.sv
`default_nettype none
package vspg_pkg;

  localparam int unsigned CoordW = 44;

  localparam logic [2:0] ReqRead   = 3'd0;
  localparam logic [2:0] ReqWrite  = 3'd1;
  localparam logic [2:0] ReqAdd    = 3'd2;
  localparam logic [2:0] ReqStamp  = 3'd3;
  localparam logic [2:0] ReqRemove = 3'd4;

  localparam logic [1:0] CfgBase  = 2'd0;
  localparam logic [1:0] CfgDecay = 2'd1;
  localparam logic [1:0] CfgInv   = 2'd2;

  localparam logic signed [31:0] OutsideMark = 32'sd25600000;

  // Classified request handed from the front to the back
  typedef struct packed {
    logic [2:0]                req;
    logic signed [CoordW-1:0]  x;
    logic signed [CoordW-1:0]  y;
    logic signed [CoordW-1:0]  z;
    logic signed [31:0]        data;
    logic                      in_box;
  } vspg_cmd_t;

  // Saturating add of a 33-bit signed delta
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [32:0] b);
    logic signed [33:0] s;
    s = 34'(a) + 34'(b);
    if (s > 34'sd2147483647) return 32'sh7fffffff;
    if (s < -34'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  // Round a Q.16 value half away from zero
  function automatic logic signed [CoordW-1:0] round_q16(input logic signed [CoordW-1:0] v);
    logic [CoordW-1:0] m;
    logic [CoordW-1:0] r;
    m = v[CoordW-1] ? CoordW'(-v) : CoordW'(v);
    r = (m + CoordW'(32768)) >> 16;
    return v[CoordW-1] ? -$signed(r) : $signed(r);
  endfunction

endpackage
`default_nettype wire

// File: rtl/vspg_front.sv
`default_nettype none
module vspg_front #(
  parameter int unsigned GRID_EDGE = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [2:0]               req_type_i,
  input  wire logic signed [23:0]       pos_x_i,
  input  wire logic signed [23:0]       pos_y_i,
  input  wire logic signed [23:0]       pos_z_i,
  input  wire logic signed [31:0]       data_value_i,
  input  wire logic [15:0]              inv_cell_i,
  output logic                          cmd_valid_o,
  input  wire logic                     cmd_ready_i,
  output vspg_pkg::vspg_cmd_t           cmd_o
);
  import vspg_pkg::*;

  localparam logic signed [CoordW-1:0] Half = CoordW'(GRID_EDGE / 2) <<< 16;
  localparam logic signed [CoordW-1:0] Edge = CoordW'(GRID_EDGE);

  // Stage 1: multiply each axis by the reciprocal cell size
  logic               s1_valid_q;
  logic [2:0]         s1_req_q;
  logic signed [CoordW-1:0] s1_px_q, s1_py_q, s1_pz_q;
  logic signed [31:0] s1_data_q;
  // Stage 2: rounded, classified command
  logic               s2_valid_q;
  vspg_cmd_t          s2_q;
  logic signed [CoordW-1:0] rx, ry, rz;
  logic               s1_adv, s2_free;

  assign s2_free    = !s2_valid_q || cmd_ready_i;
  assign s1_adv     = s1_valid_q && s2_free;
  assign in_ready_o = !s1_valid_q || s2_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (s2_free) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_req_q  <= req_type_i;
      s1_px_q   <= CoordW'(pos_x_i) * $signed({1'b0, inv_cell_i});
      s1_py_q   <= CoordW'(pos_y_i) * $signed({1'b0, inv_cell_i});
      s1_pz_q   <= CoordW'(pos_z_i) * $signed({1'b0, inv_cell_i});
      s1_data_q <= data_value_i;
    end
  end

  // Centre x and z, round, test the box
  assign rx = round_q16(s1_px_q + Half);
  assign ry = round_q16(s1_py_q);
  assign rz = round_q16(s1_pz_q + Half);

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_q.req    <= s1_req_q;
      s2_q.x      <= rx;
      s2_q.y      <= ry;
      s2_q.z      <= rz;
      s2_q.data   <= s1_data_q;
      s2_q.in_box <= rx >= 0 && ry >= 0 && rz >= 0 && rx < Edge && ry < Edge && rz < Edge;
    end
  end

  assign cmd_valid_o = s2_valid_q;
  assign cmd_o       = s2_q;
endmodule
`default_nettype wire

// File: rtl/vspg_back.sv
`default_nettype none
module vspg_back #(
  parameter int unsigned GRID_EDGE  = 32,
  parameter int unsigned MAX_LAYERS = 10
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cmd_valid_i,
  output logic                     cmd_ready_o,
  input  wire vspg_pkg::vspg_cmd_t cmd_i,
  input  wire logic [30:0]         base_weight_i,
  input  wire logic [15:0]         decay_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic signed [31:0]       read_value_o,
  output logic                     inside_box_o
);
  import vspg_pkg::*;

  localparam int unsigned AW    = $clog2(GRID_EDGE);
  localparam int unsigned IW    = 3 * AW;
  localparam int unsigned DEPTH = 1 << IW;
  localparam int unsigned LW    = $clog2(MAX_LAYERS + 1);
  localparam logic signed [CoordW-1:0] Edge = CoordW'(GRID_EDGE);
  localparam logic signed [CoordW-1:0] MaxL = CoordW'(MAX_LAYERS);

  localparam logic [3:0] StClear = 4'd0, StIdle = 4'd1, StRd = 4'd2, StRdW = 4'd3;
  localparam logic [3:0] StOut = 4'd4, StLayer = 4'd5, StCell = 4'd6, StPRd = 4'd7;
  localparam logic [3:0] StPWr = 4'd8, StDecay = 4'd9, StMod = 4'd10;

  logic signed [31:0] mem_q [DEPTH];
  logic signed [31:0] rdata_q;
  logic [3:0]  state_q;
  logic [IW:0] clr_q;
  vspg_cmd_t   cmd_q;
  logic [LW-1:0] layers_q, li_q;
  logic signed [CoordW-1:0] j_q, k_q, cy;
  logic [31:0] w_q;
  logic [47:0] prod_q;
  logic        ov_q;
  logic signed [31:0] rv_q, wrv_q;
  logic        in_q, win_q;
  logic [IW-1:0] addr_q;
  logic signed [CoordW-1:0] cx, cz, li_s;
  logic        cell_in;

  assign li_s = CoordW'(li_q);
  assign cx = cmd_q.x + j_q;
  assign cz = cmd_q.z + k_q;
  assign cy = cmd_q.y - li_s;
  assign cell_in = cx >= 0 && cz >= 0 && cy >= 0 && cx < Edge && cz < Edge && cy < Edge;

  assign cmd_ready_o  = state_q == StIdle;
  assign out_valid_o  = ov_q;
  assign read_value_o = rv_q;
  assign inside_box_o = in_q;

  // Registered memory read
  always_ff @(posedge clk_i) rdata_q <= mem_q[addr_q];

  // Memory writes: clearing pass, plain writes, read-modify-write
  always_ff @(posedge clk_i) begin
    if (state_q == StClear) mem_q[clr_q[IW-1:0]] <= '0;
    else if (state_q == StMod) begin
      if (cmd_q.req == ReqWrite) mem_q[addr_q] <= cmd_q.data;
      else if (cmd_q.req == ReqAdd) mem_q[addr_q] <= sat_add(rdata_q, 33'(cmd_q.data));
    end else if (state_q == StPWr)
      mem_q[addr_q] <= sat_add(rdata_q, cmd_q.req == ReqRemove ?
                               -$signed({1'b0, w_q}) : $signed({1'b0, w_q}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      // Raise the result when handed over, drop it once transferred
      if (state_q == StOut && (!ov_q || out_ready_i)) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      case (state_q)
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (IW + 1)'(DEPTH - 1)) state_q <= StIdle;
        end
        StIdle: if (cmd_valid_i) state_q <= StRd;
        StRd: begin
          if (cmd_q.req == ReqStamp || cmd_q.req == ReqRemove) state_q <= StLayer;
          else if (cmd_q.in_box && (cmd_q.req == ReqRead || cmd_q.req == ReqWrite ||
                   cmd_q.req == ReqAdd)) state_q <= StRdW;
          else state_q <= StOut;
        end
        StRdW: state_q <= StMod;
        StMod: state_q <= StOut;
        StLayer: state_q <= (li_q == layers_q) ? StOut : StCell;
        StCell: state_q <= cell_in ? StPRd : StDecay;
        StPRd: state_q <= StPWr;
        StPWr: state_q <= StDecay;
        StDecay: state_q <= StLayer;
        StOut: if (!ov_q || out_ready_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  // Datapath registers; StDecay advances the square scan or the layer
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        cmd_q <= cmd_i;
      end
      StRd: begin
        addr_q <= {cmd_q.z[AW-1:0], cmd_q.y[AW-1:0], cmd_q.x[AW-1:0]};
        win_q  <= cmd_q.in_box;
        wrv_q  <= (cmd_q.req == ReqRead && !cmd_q.in_box) ? OutsideMark : '0;
        li_q   <= '0;
        j_q    <= '0;
        k_q    <= '0;
        w_q    <= {1'b0, base_weight_i};
        if (cmd_q.y <= 0) layers_q <= '0;
        else if (cmd_q.y < MaxL) layers_q <= LW'(cmd_q.y);
        else layers_q <= LW'(MAX_LAYERS);
      end
      StMod: if (cmd_q.req == ReqRead) wrv_q <= rdata_q;
      StCell: begin
        addr_q <= {cz[AW-1:0], cy[AW-1:0], cx[AW-1:0]};
        prod_q <= w_q * decay_i + 48'd32768;
      end
      StDecay: begin
        if (k_q != li_s) k_q <= k_q + 1;
        else if (j_q != li_s) begin
          k_q <= -li_s;
          j_q <= j_q + 1;
        end else begin
          li_q <= li_q + 1'b1;
          j_q  <= -(li_s + 1);
          k_q  <= -(li_s + 1);
          w_q  <= prod_q[47:16];
        end
      end
      // Hand the finished result to the output register
      StOut: if (!ov_q || out_ready_i) begin
        rv_q <= wrv_q;
        in_q <= win_q;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/voxel_shadow_pyramid_grid_core.sv
`default_nettype none
// Shadow voxel grid of GRID_EDGE^3 signed Q23.8 words in one single-port memory.
// After reset a clearing pass zeroes all 2^(3*ceil(log2 GRID_EDGE)) words (32768 by
// default) before the back takes the first request. A two-stage front scales and
// rounds the position while the back serves the previous request; the back
// handles one request at a time from its memory port. A stamp or removal scans
// each (2i+1)^2 layer square in turn, up to 1330 cells for ten layers.
module voxel_shadow_pyramid_grid_core #(
  parameter int unsigned GRID_EDGE  = 32,
  parameter int unsigned MAX_LAYERS = 10
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         req_type_i,
  input  wire logic signed [23:0] pos_x_i,
  input  wire logic signed [23:0] pos_y_i,
  input  wire logic signed [23:0] pos_z_i,
  input  wire logic signed [31:0] data_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      read_value_o,
  output logic                    inside_box_o
);
  import vspg_pkg::*;

  logic [30:0] base_q;
  logic [15:0] decay_q, inv_q;
  logic        cmd_valid, cmd_ready;
  vspg_cmd_t   cmd;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= 31'd256;
      decay_q <= 16'd32768;
      inv_q   <= 16'd256;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgBase:  base_q  <= cfg_data_i[30:0];
        CfgDecay: decay_q <= cfg_data_i[15:0];
        CfgInv:   inv_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  vspg_front #(.GRID_EDGE(GRID_EDGE)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .req_type_i, .pos_x_i, .pos_y_i,
    .pos_z_i, .data_value_i, .inv_cell_i(inv_q), .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  vspg_back #(.GRID_EDGE(GRID_EDGE), .MAX_LAYERS(MAX_LAYERS)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .base_weight_i(base_q), .decay_i(decay_q), .out_valid_o, .out_ready_i,
    .read_value_o, .inside_box_o
  );
endmodule
`default_nettype wire
